// ===== rtl/slpg_pkg.sv =====
package slpg_pkg;

  // datapath sizes
  localparam int DUTY_BITS        = 13;
  localparam int SINE_TABLE_DEPTH = 256;  // power of two
  localparam int PULSE_PERIOD_MS  = 1350;

  localparam int IDX_BITS   = $clog2(SINE_TABLE_DEPTH);
  localparam int PULSE_BITS = $clog2(PULSE_PERIOD_MS);
  localparam int SINCE_BITS = 17;
  localparam int BLINK_BITS = 8;
  localparam int PHASE_BITS = 32;
  localparam int OVR_BITS   = 16;
  localparam int CFG_BITS   = 32;
  localparam int SQ_BITS    = 32;
  localparam int PROD_BITS  = SQ_BITS + DUTY_BITS;

  localparam logic [DUTY_BITS-1:0]  DUTY_FULL = DUTY_BITS'((1 << DUTY_BITS) - 1);
  localparam logic [SINCE_BITS-1:0] SINCE_MAX = '1;

  // blink timing (ms)
  localparam logic [BLINK_BITS-1:0] BLINK_LAST   = BLINK_BITS'(199);
  localparam logic [BLINK_BITS-1:0] STROBE_STEP  = BLINK_BITS'(50);
  localparam logic [BLINK_BITS-1:0] PANIC_ON     = BLINK_BITS'(100);
  localparam logic [BLINK_BITS-1:0] STROBE_STEP3 = BLINK_BITS'(150);

  // double pulse timing (ms)
  localparam logic [PULSE_BITS-1:0] PULSE_LAST    = PULSE_BITS'(PULSE_PERIOD_MS - 1);
  localparam logic [PULSE_BITS-1:0] PULSE1_END    = PULSE_BITS'(100);
  localparam logic [PULSE_BITS-1:0] PULSE2_START  = PULSE_BITS'(250);
  localparam logic [PULSE_BITS-1:0] PULSE2_END    = PULSE_BITS'(350);

  // command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // reset values of the configuration registers
  localparam logic [OVR_BITS-1:0]   OVERRIDE_RESET = OVR_BITS'(5000);
  localparam logic [PHASE_BITS-1:0] STEP_RESET     = PHASE_BITS'(1288490);

  // action codes
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_TOGGLE = 2'd2;

  // ota status codes
  localparam logic [1:0] OTA_NONE    = 2'd0;
  localparam logic [1:0] OTA_ACTIVE  = 2'd1;
  localparam logic [1:0] OTA_SUCCESS = 2'd2;
  localparam logic [1:0] OTA_FAILED  = 2'd3;

  // mode codes
  localparam logic [2:0] MODE_HOLD    = 3'd0;
  localparam logic [2:0] MODE_STROBE  = 3'd1;
  localparam logic [2:0] MODE_SOLID   = 3'd2;
  localparam logic [2:0] MODE_PANIC   = 3'd3;
  localparam logic [2:0] MODE_BREATHE = 3'd4;
  localparam logic [2:0] MODE_PULSE   = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_ACTIVE_LOW = 2'd0;
  localparam logic [1:0] CFG_OVERRIDE   = 2'd1;
  localparam logic [1:0] CFG_STEP       = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic       manual_on;
    logic [1:0] ota_status;
    logic       connected;
  } in_req_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    logic [2:0]           mode;
  } out_resp_t;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_HOLD,
    KIND_BREATHE
  } cmd_kind_t;

  // classified request handed from front to back
  typedef struct packed {
    cmd_kind_t             kind;
    logic [DUTY_BITS-1:0]  duty;
    logic [2:0]            mode;
    logic [PHASE_BITS-1:0] phase;
    logic                  active_low;
  } cmd_t;

  typedef logic [15:0] sine_lut_t [SINE_TABLE_DEPTH];

  // quarter-wave sine in Q1.15, series evaluated in Q30 at elaboration
  function automatic sine_lut_t build_sine();
    sine_lut_t         lut;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint unsigned   r;
    longint            sum;
    int                i;
    int                k;
    for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
      x    = (64'd1686629713 * longint'(i)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (k = 1; k <= 6; k++) begin
        term = (term * x2) >> 30;
        case (k)
          1:       term = term / 6;
          2:       term = term / 20;
          3:       term = term / 42;
          4:       term = term / 72;
          5:       term = term / 110;
          default: term = term / 156;
        endcase
        if (k % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      r = (longint'(sum) + 64'd16384) >> 15;
      if (r > 64'd32767) r = 64'd32767;
      lut[i] = r[15:0];
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine();

endpackage

// ===== rtl/status_led_pattern_generator.sv =====
// Status LED pattern generator. Each request is a 1 ms tick, a manual set or a
// manual toggle, and each yields one result: the PWM duty (after active_low
// polarity) and the active mode. One request is taken per clock while the
// queue is not full; each result passes through the lookup, square and scale
// stages of the breathing path. The front end keeps all timers and the
// breathing phase and classifies the request, a four-entry queue decouples
// it from the back end, and a single output register holds the oldest result
// until popped. The user is to write configuration through cfg_we, cfg_index
// and cfg_wdata only while the block is idle; the block does not enforce it.
module status_led_pattern_generator
  import slpg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                push,
  output logic                full,
  input  in_req_t             in_req,
  output logic                empty,
  input  logic                pop,
  output out_resp_t           out_resp
);

  logic q_wr;
  logic q_rd;
  logic q_full;
  logic q_empty;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  // request classification and timers
  slpg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .push      (push),
    .full      (full),
    .in_req    (in_req),
    .q_wr      (q_wr),
    .q_cmd     (wr_cmd),
    .q_full    (q_full)
  );

  // command queue
  slpg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_cmd  (wr_cmd),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_cmd  (rd_cmd),
    .q_empty (q_empty)
  );

  // duty computation and result register
  slpg_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_cmd    (rd_cmd),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_resp (out_resp)
  );

endmodule

// ===== rtl/slpg_front.sv =====
module slpg_front
  import slpg_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                push,
  output logic                full,
  input  in_req_t             in_req,
  output logic                q_wr,
  output cmd_t                q_cmd,
  input  logic                q_full
);

  logic                  active_low_r;
  logic [OVR_BITS-1:0]   override_ms_r;
  logic [PHASE_BITS-1:0] step_r;

  logic [SINCE_BITS-1:0] since_r, since_nxt;
  logic                  level_r, level_nxt;
  logic [BLINK_BITS-1:0] blink_r, blink_nxt;
  logic [PULSE_BITS-1:0] pulse_r, pulse_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;

  logic strobe_on;
  logic panic_on;
  logic pulse_on;

  assign full = q_full;
  assign q_wr = push && !q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_low_r  <= 1'b0;
      override_ms_r <= OVERRIDE_RESET;
      step_r        <= STEP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ACTIVE_LOW: active_low_r  <= cfg_wdata[0];
        CFG_OVERRIDE:   override_ms_r <= cfg_wdata[OVR_BITS-1:0];
        CFG_STEP:       step_r        <= cfg_wdata[PHASE_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // pattern timers and manual state
  always_comb begin
    since_nxt = since_r;
    level_nxt = level_r;
    blink_nxt = blink_r;
    pulse_nxt = pulse_r;
    phase_nxt = phase_r;
    case (in_req.action)
      ACT_SET: begin
        level_nxt = in_req.manual_on;
        since_nxt = '0;
      end
      ACT_TOGGLE: begin
        level_nxt = !level_r;
        since_nxt = '0;
      end
      ACT_TICK: begin
        if (since_r != SINCE_MAX) since_nxt = since_r + 1'b1;
        blink_nxt = (blink_r == BLINK_LAST) ? '0 : blink_r + 1'b1;
        pulse_nxt = (pulse_r == PULSE_LAST) ? '0 : pulse_r + 1'b1;
        phase_nxt = phase_r + step_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r <= SINCE_MAX;
      level_r <= 1'b0;
      blink_r <= '0;
      pulse_r <= '0;
      phase_r <= '0;
    end else if (q_wr) begin
      since_r <= since_nxt;
      level_r <= level_nxt;
      blink_r <= blink_nxt;
      pulse_r <= pulse_nxt;
      phase_r <= phase_nxt;
    end
  end

  // on/off decisions of the blink patterns
  assign strobe_on = (blink_nxt >= STROBE_STEP && blink_nxt < PANIC_ON) ||
                     (blink_nxt >= STROBE_STEP3);
  assign panic_on  = blink_nxt >= PANIC_ON;
  assign pulse_on  = (pulse_nxt < PULSE1_END) ||
                     (pulse_nxt >= PULSE2_START && pulse_nxt < PULSE2_END);

  // classify the request
  always_comb begin
    q_cmd.kind       = KIND_HOLD;
    q_cmd.duty       = '0;
    q_cmd.mode       = MODE_HOLD;
    q_cmd.phase      = phase_nxt;
    q_cmd.active_low = active_low_r;
    case (in_req.action)
      ACT_SET, ACT_TOGGLE: begin
        q_cmd.kind = KIND_DIRECT;
        q_cmd.duty = {DUTY_BITS{level_nxt ^ active_low_r}};
      end
      ACT_TICK: begin
        case (in_req.ota_status)
          OTA_ACTIVE: begin
            q_cmd.kind = KIND_DIRECT;
            q_cmd.mode = MODE_STROBE;
            q_cmd.duty = {DUTY_BITS{strobe_on ^ active_low_r}};
          end
          OTA_SUCCESS: begin
            q_cmd.kind = KIND_DIRECT;
            q_cmd.mode = MODE_SOLID;
            q_cmd.duty = {DUTY_BITS{!active_low_r}};
          end
          OTA_FAILED: begin
            q_cmd.kind = KIND_DIRECT;
            q_cmd.mode = MODE_PANIC;
            q_cmd.duty = {DUTY_BITS{panic_on ^ active_low_r}};
          end
          default: begin
            if (since_nxt < {1'b0, override_ms_r}) begin
              q_cmd.kind = KIND_HOLD;
            end else if (in_req.connected) begin
              q_cmd.kind = KIND_BREATHE;
              q_cmd.mode = MODE_BREATHE;
            end else begin
              q_cmd.kind = KIND_DIRECT;
              q_cmd.mode = MODE_PULSE;
              q_cmd.duty = {DUTY_BITS{pulse_on ^ active_low_r}};
            end
          end
        endcase
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/slpg_queue.sv =====
module slpg_queue
  import slpg_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  cmd_t wr_cmd,
  output logic q_full,
  input  logic rd,
  output cmd_t rd_cmd,
  output logic q_empty
);

  cmd_t                 mem_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_BITS:0]   count_r;

  assign q_full  = count_r == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign q_empty = count_r == '0;
  assign rd_cmd  = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= wr_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({wr, rd})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/slpg_back.sv =====
module slpg_back
  import slpg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  cmd_t      q_cmd,
  output logic      q_rd,
  output logic      empty,
  input  logic      pop,
  output out_resp_t out_resp
);

  logic                 v1_r, v2_r, v3_r;
  cmd_t                 c1_r, c2_r;
  logic [15:0]          u1_r;
  logic [SQ_BITS-1:0]   sq2_r;
  out_resp_t            res3_r;
  logic [DUTY_BITS-1:0] held_r;

  logic                 adv1, adv2, adv3;
  logic [1:0]           quad;
  logic [IDX_BITS-1:0]  idx;
  logic [14:0]          mag;
  logic [15:0]          u_nxt;
  logic [PROD_BITS-1:0] prod;
  logic [DUTY_BITS-1:0] level;
  logic [DUTY_BITS-1:0] duty_nxt;

  // stage advance, a bubble never blocks the stage behind it
  assign adv3 = v2_r && (!v3_r || pop);
  assign adv2 = v1_r && (!v2_r || adv3);
  assign adv1 = !q_empty && (!v1_r || adv2);
  assign q_rd = adv1;

  assign empty    = !v3_r;
  assign out_resp = res3_r;

  // quarter-wave lookup and offset to unsigned
  assign quad = q_cmd.phase[PHASE_BITS-1 -: 2];
  assign idx  = q_cmd.phase[PHASE_BITS-3 -: IDX_BITS];
  always_comb begin
    if (quad[0]) begin
      mag = (idx == '0) ? 15'h7fff : SINE_LUT[IDX_BITS'(~idx + 1'b1)][14:0];
    end else begin
      mag = SINE_LUT[idx][14:0];
    end
    if (quad[1]) u_nxt = 16'h8000 - {1'b0, mag};
    else         u_nxt = {1'b1, mag};
  end

  // square scaled to full duty, then polarity and hold selection
  assign prod  = PROD_BITS'(sq2_r) * PROD_BITS'(DUTY_FULL);
  assign level = prod[PROD_BITS-1 -: DUTY_BITS];
  always_comb begin
    case (c2_r.kind)
      KIND_DIRECT:  duty_nxt = c2_r.duty;
      KIND_BREATHE: duty_nxt = c2_r.active_low ? (DUTY_FULL - level) : level;
      default:      duty_nxt = held_r;
    endcase
  end

  // valid bits and the held duty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      held_r <= '0;
    end else begin
      if (adv1)      v1_r <= 1'b1;
      else if (adv2) v1_r <= 1'b0;
      if (adv2)      v2_r <= 1'b1;
      else if (adv3) v2_r <= 1'b0;
      if (adv3)      v3_r <= 1'b1;
      else if (pop)  v3_r <= 1'b0;
      if (adv3)      held_r <= duty_nxt;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv1) begin
      c1_r <= q_cmd;
      u1_r <= u_nxt;
    end
    if (adv2) begin
      c2_r  <= c1_r;
      sq2_r <= u1_r * u1_r;
    end
    if (adv3) begin
      res3_r.duty <= duty_nxt;
      res3_r.mode <= c2_r.mode;
    end
  end

endmodule
